>>> hw/rtl/pidq16_pkg.sv
// shared widths, register addresses and operation codes for the pid controller
package pidq16_pkg;

    // fraction bits of the q gains
    localparam int FRAC_BITS = 16;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 32;
    localparam int LIMIT_W = 31;

    // e - last_error and e + last_error carry one extra bit
    localparam int EXT_W   = DATA_W + 1;
    localparam int PROD_W  = GAIN_W + EXT_W;
    // a shifted product of a gain and an extended value fits here exactly
    localparam int TERM_W  = PROD_W - FRAC_BITS;
    // room for p + d + i with no wrap
    localparam int ACC_W   = TERM_W + 2;

    localparam int PADDR_W = 4;

    localparam logic [PADDR_W-1:0] ADDR_KP    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_KI    = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_KD    = 4'h8;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = 4'hC;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage

>>> hw/rtl/pidq16_in_if.sv
// input channel: operation and error sample
interface pidq16_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic signed [pidq16_pkg::DATA_W-1:0]  error_sample;

    modport source (output valid, output op, output error_sample, input ready);
    modport sink   (input valid, input op, input error_sample, output ready);
endinterface

>>> hw/rtl/pidq16_out_if.sv
// output channel: clamped drive value
interface pidq16_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidq16_pkg::DATA_W-1:0]  drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

>>> hw/rtl/pid_controller_q16_unit.sv
// Discrete PID controller with trapezoidal integral, Q16.16 gains. A word is
// captured in an input register, the three gain products, the integral update
// and both clamps are formed in one combinational pass, and the drive value
// lands in an output register. One word is taken every cycle while the output
// register drains. The integral and last-error history update as a word leaves
// the input register, so the next word already sees them. Gains and the clamp
// limit are written through the APB port; the user must write them only while
// the block is idle, as the block itself does not enforce it.
module pid_controller_q16_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pidq16_in_if.sink                          i_in,
    pidq16_out_if.source                       o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidq16_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int DW = pidq16_pkg::DATA_W;
    localparam int GW = pidq16_pkg::GAIN_W;
    localparam int LW = pidq16_pkg::LIMIT_W;
    localparam int XW = pidq16_pkg::EXT_W;
    localparam int PW = pidq16_pkg::PROD_W;
    localparam int TW = pidq16_pkg::TERM_W;
    localparam int AW = pidq16_pkg::ACC_W;

    // configuration
    logic signed [GW-1:0] r_kp, r_ki, r_kd;
    logic        [LW-1:0] r_limit;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_limit <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                pidq16_pkg::ADDR_KP:    r_kp    <= pwdata;
                pidq16_pkg::ADDR_KI:    r_ki    <= pwdata;
                pidq16_pkg::ADDR_KD:    r_kd    <= pwdata;
                pidq16_pkg::ADDR_LIMIT: r_limit <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            pidq16_pkg::ADDR_KP:    prdata = r_kp;
            pidq16_pkg::ADDR_KI:    prdata = r_ki;
            pidq16_pkg::ADDR_KD:    prdata = r_kd;
            pidq16_pkg::ADDR_LIMIT: prdata = {1'b0, r_limit};
            default:                prdata = '0;
        endcase
    end

    // input register and output register handshake
    logic                 r_s1_vld, r_s1_op;
    logic signed [DW-1:0] r_s1_err;
    logic                 r_out_vld;
    logic signed [DW-1:0] r_out_drive;
    logic                 s1_adv, in_acc;

    assign s1_adv     = r_s1_vld & (~r_out_vld | o_out.ready);
    assign i_in.ready = ~r_s1_vld | s1_adv;
    assign in_acc     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= i_in.op;
            r_s1_err <= i_in.error_sample;
        end
    end

    // history
    logic signed [DW-1:0] r_last_err, r_last_int;
    logic signed [DW-1:0] n_last_int, n_drive;

    // datapath
    logic signed [XW-1:0] diff, csum;
    logic signed [PW-1:0] prod_p, prod_d, prod_i;
    logic signed [TW-1:0] term_p, term_d, term_i;
    logic signed [AW-1:0] lim_pos, lim_neg, int_pre, tot_pre, int_clamped;

    assign diff   = XW'(r_s1_err) - XW'(r_last_err);
    assign csum   = XW'(r_s1_err) + XW'(r_last_err);
    assign prod_p = PW'(r_kp) * PW'(r_s1_err);
    assign prod_d = PW'(r_kd) * PW'(diff);
    assign prod_i = PW'(r_ki) * PW'(csum);
    // arithmetic shift floors the gain products
    assign term_p = TW'(prod_p >>> pidq16_pkg::FRAC_BITS);
    assign term_d = TW'(prod_d >>> pidq16_pkg::FRAC_BITS);
    assign term_i = TW'(prod_i >>> pidq16_pkg::FRAC_BITS);

    assign lim_pos = AW'($signed({1'b0, r_limit}));
    assign lim_neg = -lim_pos;

    assign int_pre = AW'(r_last_int) + AW'(term_i);

    always_comb begin
        if (int_pre > lim_pos) begin
            int_clamped = lim_pos;
        end else if (int_pre < lim_neg) begin
            int_clamped = lim_neg;
        end else begin
            int_clamped = int_pre;
        end
    end

    assign n_last_int = int_clamped[DW-1:0];
    assign tot_pre    = AW'(term_p) + AW'(term_d) + int_clamped;

    always_comb begin
        if (tot_pre > lim_pos) begin
            n_drive = lim_pos[DW-1:0];
        end else if (tot_pre < lim_neg) begin
            n_drive = lim_neg[DW-1:0];
        end else begin
            n_drive = tot_pre[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_last_int <= '0;
        end else if (s1_adv) begin
            if (r_s1_op == pidq16_pkg::OP_CLEAR) begin
                r_last_err <= '0;
                r_last_int <= '0;
            end else begin
                r_last_err <= r_s1_err;
                r_last_int <= n_last_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_drive <= (r_s1_op == pidq16_pkg::OP_CLEAR) ? '0 : n_drive;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.drive_value = r_out_drive;

    // a clear word empties the history and drives zero
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_op == pidq16_pkg::OP_CLEAR
        |=> r_out_drive == '0 && r_last_err == '0 && r_last_int == '0)
        else $error("clear word did not zero history and drive");

    // drive value stays inside the limit in force when it was formed
    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> AW'(r_out_drive) <= $past(lim_pos)
                && AW'(r_out_drive) >= $past(lim_neg))
        else $error("drive value outside clamp limit");

    // stored integral stays inside the limit
    a_int_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> AW'(r_last_int) <= $past(lim_pos)
                && AW'(r_last_int) >= $past(lim_neg))
        else $error("integral history outside clamp limit");

    // history only moves when a word leaves the input register
    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_last_err) && $stable(r_last_int))
        else $error("history changed without a word");

    // a waiting result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |-> !s1_adv)
        else $error("output register overwritten while stalled");

endmodule
